[hdl/mag_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_pkg: shared types, constants and byte functions for the MAGENTA core
// Exponent table, the pi byte-pair step, the S byte shuffle and the stage
// record that travels down the cell chain.
// ----------------------------------------------------------------------------
package mag_pkg;

  // Cipher geometry
  localparam int unsigned MAG_ROUNDS      = 6;
  localparam int unsigned PI_PER_T        = 4;
  localparam int unsigned T_PER_F         = 3;
  localparam int unsigned STEPS_PER_ROUND = PI_PER_T * T_PER_F;
  localparam int unsigned NUM_STEPS       = MAG_ROUNDS * STEPS_PER_ROUND;

  // Rounds (counted from 0) that use the second key half
  localparam int unsigned K2_ROUND_LO = 2;
  localparam int unsigned K2_ROUND_HI = 3;

  // Generator feedback of x^8+x^6+x^5+x^2+1 and the carry bit
  localparam logic [8:0] EXP_FEEDBACK = 9'h065;
  localparam logic [8:0] EXP_CARRY    = 9'h100;

  // Configuration register indexes
  localparam logic REG_KEY_FIRST  = 1'b0;
  localparam logic REG_KEY_SECOND = 1'b1;

  // Record carried from cell to cell
  typedef struct packed {
    logic         dec;  // decrypt request
    logic [63:0]  x1;   // left Feistel half
    logic [63:0]  x2;   // right Feistel half
    logic [127:0] c;    // round-function work word
  } stage_t;

  // Exponent table, entry i at bits [8*i +: 8], built at elaboration
  function automatic logic [2047:0] build_exp();
    logic [2047:0] tab;
    logic [8:0]    v;
    tab = '0;
    v   = 9'd1;
    tab[7:0] = 8'h01;
    for (int i = 1; i < 255; i++) begin
      v = {v[7:0], 1'b0};
      if ((v & EXP_CARRY) != 9'd0) begin
        v = v ^ EXP_FEEDBACK;
      end
      tab[8*i +: 8] = v[7:0];
    end
    tab[2047:2040] = 8'h00;
    return tab;
  endfunction

  localparam logic [2047:0] EXP_TAB = build_exp();

  function automatic logic [7:0] exp_lut(input logic [7:0] a);
    return EXP_TAB[{a, 3'b000} +: 8];
  endfunction

  // A(x, y) = f[x ^ f[y]]
  function automatic logic [7:0] mag_a(input logic [7:0] x, input logic [7:0] y);
    return exp_lut(x ^ exp_lut(y));
  endfunction

  // Byte 0 sits in the top bits
  function automatic logic [7:0] get_byte(input logic [127:0] v, input int unsigned i);
    return v[127 - 8*i -: 8];
  endfunction

  // pi: byte i pairs with byte i+8
  function automatic logic [127:0] mag_pi(input logic [127:0] v);
    logic [127:0] t;
    t = '0;
    for (int unsigned i = 0; i < 8; i++) begin
      t[127 - 16*i -: 8]     = mag_a(get_byte(v, i), get_byte(v, i + 8));
      t[127 - 16*i - 8 -: 8] = mag_a(get_byte(v, i + 8), get_byte(v, i));
    end
    return t;
  endfunction

  // S: even bytes first, then odd bytes
  function automatic logic [127:0] mag_s(input logic [127:0] x);
    logic [127:0] o;
    o = '0;
    for (int unsigned i = 0; i < 8; i++) begin
      o[127 - 8*i -: 8]      = get_byte(x, 2*i);
      o[127 - 8*(i+8) -: 8]  = get_byte(x, 2*i + 1);
    end
    return o;
  endfunction

endpackage

[hdl/mag_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mag_cell: one pi step of the MAGENTA cell chain
// Applies one pi to the work word and registers it. Its place in the chain
// decides whether it first loads X2||K, folds back S(C) xor (X2||K), and
// whether it closes a Feistel round.
// ----------------------------------------------------------------------------
module mag_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  mag_pkg::stage_t data_i,
  input  logic [63:0]     key_i,
  output logic            valid_o,
  output mag_pkg::stage_t data_o
);

  localparam int unsigned POS = STEP % mag_pkg::STEPS_PER_ROUND;
  localparam bit ROUND_START  = (POS == 0);
  localparam bit FOLD_BACK    = (POS % mag_pkg::PI_PER_T == 0) && (POS != 0);
  localparam bit ROUND_END    = (POS == mag_pkg::STEPS_PER_ROUND - 1);

  logic            valid_q;
  mag_pkg::stage_t data_q, data_d;
  logic [127:0]    w, c_in, c_pi, s_out;

  // Work word into this step, pi, and the round close
  always_comb begin
    w = {data_i.x2, key_i};
    if (ROUND_START) begin
      c_in = w;
    end else if (FOLD_BACK) begin
      c_in = w ^ mag_pkg::mag_s(data_i.c);
    end else begin
      c_in = data_i.c;
    end
    c_pi   = mag_pkg::mag_pi(c_in);
    s_out  = mag_pkg::mag_s(c_pi);
    data_d = data_i;
    data_d.c = c_pi;
    if (ROUND_END) begin
      data_d.x1 = data_i.x2;
      data_d.x2 = data_i.x1 ^ s_out[127:64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[hdl/magenta_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magenta_block_cipher: MAGENTA-128 encrypt/decrypt, one block per cycle
// while m_axis is ready. Six Feistel rounds unrolled into a chain of 72 pi
// cells plus an output register; key halves come from a plain write port.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake              | payload
//  s_axis   | in  | s_axis_tvalid/tready   | tdata: block_high, block_low
//           |     |                        | tuser: req_type
//  m_axis   | out | m_axis_tvalid/tready   | tdata: result_high, result_low
//  cfg      | in  | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
//  One request per cycle sustained while m_axis is ready; a block passes
//  one pi step per cell (72 cells) plus the output register.
//  Reset clears all valid bits and both key halves to zero.
//  The chain shifts whenever its tail is empty or the output register can
//  take the tail, so bubbles close up while a result waits downstream.
// ----------------------------------------------------------------------------
module magenta_block_cipher (
  input  logic         clk_i,
  input  logic         rst_ni,
  // request stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // [63:0] block_high, [127:64] block_low
  input  logic         s_axis_tuser,   // [0] req_type
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] result_high, [127:64] result_low
  // configuration
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i
);

  localparam int unsigned N = mag_pkg::NUM_STEPS;

  logic [63:0]     key1_q, key2_q;
  logic            chain_v [N+1];
  mag_pkg::stage_t chain_d [N+1];
  logic            en;
  logic            tail_v, out_load;
  logic            out_v_q, out_v_d;
  logic [127:0]    out_data_q, out_data_d;
  mag_pkg::stage_t tail;

  // Key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key1_q <= '0;
      key2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mag_pkg::REG_KEY_FIRST:  key1_q <= cfg_wdata_i;
        mag_pkg::REG_KEY_SECOND: key2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Chain entry: decrypt swaps the halves
  always_comb begin
    chain_v[0]     = s_axis_tvalid;
    chain_d[0].dec = s_axis_tuser;
    chain_d[0].x1  = s_axis_tuser ? s_axis_tdata[127:64] : s_axis_tdata[63:0];
    chain_d[0].x2  = s_axis_tuser ? s_axis_tdata[63:0]   : s_axis_tdata[127:64];
    chain_d[0].c   = '0;
  end

  // Cell chain, subkey by round: K1 K1 K2 K2 K1 K1
  for (genvar g = 0; g < N; g++) begin : g_cell
    localparam int unsigned RND = g / mag_pkg::STEPS_PER_ROUND;
    logic [63:0] key;
    if (RND == mag_pkg::K2_ROUND_LO || RND == mag_pkg::K2_ROUND_HI) begin : g_k2
      assign key = key2_q;
    end else begin : g_k1
      assign key = key1_q;
    end
    mag_cell #(
      .STEP(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(chain_v[g]),
      .data_i (chain_d[g]),
      .key_i  (key),
      .valid_o(chain_v[g+1]),
      .data_o (chain_d[g+1])
    );
  end

  // Shift control and output register
  assign tail_v   = chain_v[N];
  assign tail     = chain_d[N];
  assign out_load = tail_v && (!out_v_q || m_axis_tready);
  assign en       = !tail_v || !out_v_q || m_axis_tready;

  always_comb begin
    out_v_d = out_load || (out_v_q && !m_axis_tready);
    if (tail.dec) begin
      out_data_d = {tail.x1, tail.x2};
    end else begin
      out_data_d = {tail.x2, tail.x1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign s_axis_tready = en;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_v && out_v_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("chain shifted while tail result was blocked");

  a_enter_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> chain_v[1])
    else $error("accepted request did not enter first cell");

  a_key_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg_we_i |=> ($stable(key1_q) && $stable(key2_q)))
    else $error("key changed without a write");

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for magenta_block_cipher
// Streams encrypt and decrypt requests through the cipher under several key
// settings, with bursty request traffic and a stalling result side. Every
// accepted request is run through a local six-round MAGENTA model. Each
// result is compared half by half against the oldest predicted block.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_WAIT   = 80;     // a bit over the pass through the cell chain and output register
  localparam int unsigned PRINT_MAX   = 20;

  localparam bit OP_ENCRYPT = 1'b0;
  localparam bit OP_DECRYPT = 1'b1;

  // Byte 0 is the leftmost (most significant) byte of each vector
  typedef logic [0:7][7:0]  half_t;
  typedef logic [0:15][7:0] blk16_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  // --------------------------------------------------------------------------
  // Scoreboard: MAGENTA model plus the queue of blocks still owed by the DUT
  // --------------------------------------------------------------------------
  class cipher_sb;
    logic [7:0] exp_tab [256];
    half_t      k1, k2;
    block_t     pending_blocks [$];
    int         errors;

    function new();
      logic [8:0] v;
      v = 9'd1;
      exp_tab[0] = 8'h01;
      for (int i = 1; i < 255; i++) begin
        v = {v[7:0], 1'b0};
        if ((v & mag_pkg::EXP_CARRY) != 9'd0) begin
          v = v ^ mag_pkg::EXP_FEEDBACK;
        end
        exp_tab[i] = v[7:0];
      end
      exp_tab[255] = 8'h00;
      k1 = '0;
      k2 = '0;
      errors = 0;
    endfunction

    function logic [7:0] amix(logic [7:0] x, logic [7:0] y);
      return exp_tab[x ^ exp_tab[y]];
    endfunction

    // pi applied four times; byte i pairs with byte i+8
    function blk16_t t_step(blk16_t v);
      blk16_t t;
      for (int n = 0; n < mag_pkg::PI_PER_T; n++) begin
        for (int i = 0; i < 8; i++) begin
          t[2*i]     = amix(v[i], v[8+i]);
          t[2*i + 1] = amix(v[8+i], v[i]);
        end
        v = t;
      end
      return v;
    endfunction

    // even-indexed bytes, then odd-indexed bytes
    function blk16_t even_odd(blk16_t v);
      blk16_t o;
      for (int i = 0; i < 8; i++) begin
        o[i]     = v[2*i];
        o[8 + i] = v[2*i + 1];
      end
      return o;
    endfunction

    // round function: top half of S(C(3, x2 || sk))
    function half_t round_fn(half_t x2, half_t sk);
      blk16_t w, c;
      w = {x2, sk};
      c = t_step(w);
      for (int n = 1; n < mag_pkg::T_PER_F; n++) begin
        c = t_step(w ^ even_odd(c));
      end
      c = even_odd(c);
      return c[0:7];
    endfunction

    function block_t run_feistel(bit dec, logic [63:0] hi, logic [63:0] lo);
      half_t  l, r, nx;
      block_t res;
      if (dec) begin
        l = lo;
        r = hi;
      end else begin
        l = hi;
        r = lo;
      end
      for (int rd = 0; rd < mag_pkg::MAG_ROUNDS; rd++) begin
        nx = l ^ round_fn(r, (rd == mag_pkg::K2_ROUND_LO ||
                              rd == mag_pkg::K2_ROUND_HI) ? k2 : k1);
        l  = r;
        r  = nx;
      end
      if (dec) begin
        res.hi = r;
        res.lo = l;
      end else begin
        res.hi = l;
        res.lo = r;
      end
      return res;
    endfunction

    function void load_key(logic idx, logic [63:0] val);
      if (idx == mag_pkg::REG_KEY_FIRST) begin
        k1 = val;
      end else begin
        k2 = val;
      end
    endfunction

    function void note_request(bit dec, logic [63:0] hi, logic [63:0] lo);
      pending_blocks.push_back(run_feistel(dec, hi, lo));
    endfunction

    task flag_mismatch(string msg);
      if (errors < PRINT_MAX) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      errors++;
    endtask

    task check_block(logic [127:0] data);
      block_t exp_blk;
      if (pending_blocks.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending: %h", data));
      end else begin
        exp_blk = pending_blocks.pop_front();
        if (data[63:0] !== exp_blk.hi) begin
          flag_mismatch($sformatf("result_high got %h want %h", data[63:0], exp_blk.hi));
        end
        if (data[127:64] !== exp_blk.lo) begin
          flag_mismatch($sformatf("result_low got %h want %h", data[127:64], exp_blk.lo));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT and stimulus signals
  // --------------------------------------------------------------------------
  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;   // [63:0] block_high, [127:64] block_low
  logic         s_axis_tuser;   // [0] req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // [63:0] result_high, [127:64] result_low
  logic         cfg_we_i;
  logic         cfg_idx_i;
  logic [63:0]  cfg_wdata_i;

  cipher_sb    sb;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  int unsigned stall_left;
  int unsigned rx_cnt;

  magenta_block_cipher u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Monitors: log accepted requests, check accepted results
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      sb.note_request(s_axis_tuser, s_axis_tdata[63:0], s_axis_tdata[127:64]);
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_block(m_axis_tdata);
    end
  end

  // Result side: alternating windows, random stalls in every second one
  always @(posedge clk_i) begin
    rx_cnt <= rx_cnt + 1;
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ((rx_cnt & 512) != 0 && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(1, 8);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // One request; bursts of random length separated by random gaps
  task automatic send_block(bit dec, logic [63:0] hi, logic [63:0] lo);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= dec;
    s_axis_tdata  <= {lo, hi};
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  // Stop sending and wait until every predicted block has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_blocks.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_key(logic idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.load_key(idx, val);
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      send_block(bit'($urandom_range(0, 1)), rand_word(), rand_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    block_t ct;
    logic [63:0] key_a [6];
    logic [63:0] key_b [6];

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_ENCRYPT;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = mag_pkg::REG_KEY_FIRST;
    cfg_wdata_i   = '0;
    cycle_cnt     = 0;
    stall_left    = 0;
    rx_cnt        = 0;
    burst_left    = 1;
    sb            = new();

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // key settings per phase; phase 0 keeps the reset keys
    key_a[1] = '1;               key_b[1] = '1;
    key_a[2] = '0;               key_b[2] = '1;
    key_a[3] = '1;               key_b[3] = '0;
    key_a[4] = rand_word();      key_b[4] = rand_word();
    key_a[5] = {$urandom, $urandom}; key_b[5] = {$urandom, $urandom};

    // directed: extreme and patterned blocks, both directions, zero key
    for (int op = 0; op < 2; op++) begin
      send_block(bit'(op), 64'h0, 64'h0);
      send_block(bit'(op), '1, '1);
      send_block(bit'(op), 64'h0, '1);
      send_block(bit'(op), '1, 64'h0);
      send_block(bit'(op), 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      send_block(bit'(op), 64'h8000_0000_0000_0001, 64'h0123_4567_89AB_CDEF);
    end
    // round trip: model outputs sent back through in the other direction
    ct = sb.run_feistel(OP_ENCRYPT, 64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF);
    send_block(OP_DECRYPT, ct.hi, ct.lo);
    ct = sb.run_feistel(OP_DECRYPT, 64'hFEDC_BA98_7654_3210, 64'h0F1E_2D3C_4B5A_6978);
    send_block(OP_ENCRYPT, ct.hi, ct.lo);

    run_random(90);
    drain();

    // remaining phases, keys changed only while the pipe is empty
    for (int ph = 1; ph < 6; ph++) begin
      write_key(mag_pkg::REG_KEY_FIRST, key_a[ph]);
      write_key(mag_pkg::REG_KEY_SECOND, key_b[ph]);
      run_random(100);
      drain();
    end

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (sb.pending_blocks.size() != 0) begin
      sb.flag_mismatch($sformatf("%0d results never arrived", sb.pending_blocks.size()));
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mag_pkg.sv
hdl/mag_cell.sv
hdl/magenta_block_cipher.sv
dv/tb.sv
